[rtl/core/poly_voice_allocator_top_assert.svh]
// Assertion macros for the allocator RTL, used by the back end (pva_back).
// Each check is sampled on clk and is off while rst_n is low.
`ifndef POLY_VOICE_ALLOCATOR_TOP_ASSERT_SVH
`define POLY_VOICE_ALLOCATOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PVA_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define PVA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PVA_ASSERT_IMPLY(lbl, ante, cons, msg)
`define PVA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/core/pva_pkg.sv]
package pva_pkg;

  localparam int PITCH_W = 7;

  // Item formats on the ports
  typedef struct packed {
    logic [1:0]         operation;
    logic [PITCH_W-1:0] pitch;
    logic [6:0]         velocity;
    logic [4:0]         voice_select;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         voice_number;
    logic [PITCH_W-1:0] out_pitch;
    logic [6:0]         out_velocity;
    logic               last;
  } out_item_t;

  // Operation codes of an input item
  localparam logic [1:0] OP_NOTE  = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_SET   = 2'd3;

  // Config register select (paddr[2])
  localparam logic REG_STEAL_MODE  = 1'b0;
  localparam logic REG_VOICE_COUNT = 1'b1;

  // Classified command, front to back
  typedef enum logic [2:0] {
    CMD_NOTE_FREE,
    CMD_NOTE_STEAL,
    CMD_NOTE_OFF,
    CMD_STOP,
    CMD_CLEAR,
    CMD_SET
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [PITCH_W-1:0] pitch;
    logic [6:0]         velocity;
    logic [4:0]         voice_select;
  } cmd_t;

  // Command queue
  localparam int CMD_QDEPTH = 2;
  localparam int QPW        = 1;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_STEAL,
    BK_FLUSH
  } back_state_t;

endpackage

[rtl/core/poly_voice_allocator_top.sv]
// Channel   Ports                                   Direction  Handshake
// input     start, busy, in_item                    in         start && !busy
// result    out_valid, out_item                     out        out_valid strobe, 1 cycle
// config    psel, penable, pwrite, paddr, pwdata,   in/out     APB, pready tied high
//           prdata, pready
//
// Per item (nv = voices in use): the back end applies clear and set as it pops them.
// Note-on, note-off and stop walk the voice RAM one voice per cycle over up to nv
// voices, with a steal state for the second result. The RAM read port sets this pace.
// A 2-entry command queue sits between front and back; busy is high while it is full.
// Results go out one per cycle at most; the final one of an item has last set.
// rst_n is synchronous: all voices off and zeroed, counter zero, steal_mode 0,
// voice_count 16. No clearing pass; per-voice valid bits stand in for the RAM.
module poly_voice_allocator_top import pva_pkg::*; #(
  parameter int MAX_VOICES = 16,
  parameter int AGE_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input item channel
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  // result channel
  output logic        out_valid,
  output out_item_t   out_item,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = $clog2(MAX_VOICES + 1);
  localparam int XW = (CW > 5) ? CW : 5;

  logic          steal_mode_r, steal_mode_nxt;
  logic [4:0]    voice_count_r, voice_count_nxt;
  logic          cfg_wr;
  logic [CW-1:0] nv;

  logic          q_push, q_pop, q_empty, q_full;
  cmd_t          q_cmd, q_head;

  // ---- configuration registers ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    steal_mode_nxt  = steal_mode_r;
    voice_count_nxt = voice_count_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_STEAL_MODE:  steal_mode_nxt  = pwdata[0];
        REG_VOICE_COUNT: voice_count_nxt = pwdata[4:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steal_mode_r  <= 1'b0;
      voice_count_r <= 5'd16;
    end else begin
      steal_mode_r  <= steal_mode_nxt;
      voice_count_r <= voice_count_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_STEAL_MODE:  prdata = {31'd0, steal_mode_r};
      REG_VOICE_COUNT: prdata = {27'd0, voice_count_r};
    endcase
  end

  // zero or an oversized count means all voices
  assign nv = ((voice_count_r == '0) || (XW'(voice_count_r) > XW'(MAX_VOICES))) ?
              CW'(MAX_VOICES) : CW'(voice_count_r);

  // ---- front: accept and classify ----
  pva_front #(
    .MAX_VOICES (MAX_VOICES)
  ) u_front (
    .start      (start),
    .in_item    (in_item),
    .steal_mode (steal_mode_r),
    .nv         (nv),
    .q_full     (q_full),
    .busy       (busy),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  // ---- command queue ----
  pva_fifo u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // ---- back: voice scan and update ----
  pva_back #(
    .MAX_VOICES (MAX_VOICES),
    .AGE_BITS   (AGE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .nv        (nv),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

[rtl/core/pva_ram.sv]
module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/pva_fifo.sv]
module pva_fifo import pva_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  cmd_t           entry_r [CMD_QDEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPW:0]   cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPW+1)'(push) - (QPW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head  = entry_r[rd_ptr_r];
  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == (QPW+1)'(CMD_QDEPTH));

endmodule

[rtl/core/pva_front.sv]
module pva_front import pva_pkg::*; #(
  parameter int MAX_VOICES = 16,
  localparam int CW = $clog2(MAX_VOICES + 1),
  localparam int XW = (CW > 5) ? CW : 5
) (
  input  logic          start,
  input  in_item_t      in_item,
  input  logic          steal_mode,
  input  logic [CW-1:0] nv,
  input  logic          q_full,
  output logic          busy,
  output logic          q_push,
  output cmd_t          q_cmd
);

  logic keep;

  always_comb begin
    keep               = 1'b1;
    q_cmd.pitch        = in_item.pitch;
    q_cmd.velocity     = in_item.velocity;
    q_cmd.voice_select = in_item.voice_select;
    unique case (in_item.operation)
      OP_NOTE: begin
        if (in_item.velocity == '0) begin
          q_cmd.kind = CMD_NOTE_OFF;
        end else if (steal_mode) begin
          q_cmd.kind = CMD_NOTE_STEAL;
        end else begin
          q_cmd.kind = CMD_NOTE_FREE;
        end
      end
      OP_STOP:  q_cmd.kind = CMD_STOP;
      OP_CLEAR: q_cmd.kind = CMD_CLEAR;
      OP_SET: begin
        q_cmd.kind = CMD_SET;
        // out-of-range voice: drop here, nothing reaches the back end
        keep = (in_item.voice_select != '0) &&
               (XW'(in_item.voice_select) <= XW'(nv));
      end
    endcase
  end

  assign busy   = q_full;
  assign q_push = start && !q_full && keep;

endmodule

[rtl/core/pva_back.sv]
`include "poly_voice_allocator_top_assert.svh"

module pva_back import pva_pkg::*; #(
  parameter int MAX_VOICES = 16,
  parameter int AGE_BITS   = 32,
  localparam int IW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1,
  localparam int CW = $clog2(MAX_VOICES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [CW-1:0] nv,
  input  logic          q_empty,
  input  cmd_t          q_head,
  output logic          q_pop,
  output logic          out_valid,
  output out_item_t     out_item
);

  localparam int RW = PITCH_W + AGE_BITS;

  back_state_t state_r, state_nxt;

  cmd_t                  cmd_r, cmd_nxt;
  logic [CW-1:0]         rd_idx_r, rd_idx_nxt;
  logic [IW-1:0]         proc_idx_r, proc_idx_nxt;
  logic                  pvalid_r, pvalid_nxt;
  logic [MAX_VOICES-1:0] on_r, on_nxt;
  logic [MAX_VOICES-1:0] valid_r, valid_nxt;
  logic [AGE_BITS-1:0]   counter_r, counter_nxt;

  // oldest sounding / oldest free trackers for the steal scan
  logic                  on_fnd_r, on_fnd_nxt;
  logic [IW-1:0]         on_idx_r, on_idx_nxt;
  logic [AGE_BITS-1:0]   on_age_r, on_age_nxt;
  logic [PITCH_W-1:0]    on_pit_r, on_pit_nxt;
  logic                  off_fnd_r, off_fnd_nxt;
  logic [IW-1:0]         off_idx_r, off_idx_nxt;
  logic [AGE_BITS-1:0]   off_age_r, off_age_nxt;

  // one-deep hold so the final result of an item can carry last
  logic                  pend_valid_r, pend_valid_nxt;
  out_item_t             pend_r, pend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;

  logic                  ram_we;
  logic [IW-1:0]         ram_waddr;
  logic [PITCH_W-1:0]    ram_wpitch;
  logic [AGE_BITS-1:0]   ram_wage;
  logic [IW-1:0]         ram_raddr;
  logic [RW-1:0]         ram_rdata;

  logic                  e_on;
  logic [PITCH_W-1:0]    e_pitch;
  logic [AGE_BITS-1:0]   e_age;
  logic                  scan_hit;
  logic                  head_scans;
  logic                  emit;
  logic                  flush;
  out_item_t             emit_item;
  logic [IW-1:0]         set_idx;

  function automatic logic [4:0] vnum(input logic [IW-1:0] idx);
    logic [IW:0] s;
    s = {1'b0, idx} + (IW+1)'(1);
    return 5'(s);
  endfunction

  pva_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_VOICES)
  ) u_voice_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({ram_wpitch, ram_wage}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // entry under scan; a never-written or cleared voice reads as zero
  assign e_on    = on_r[proc_idx_r];
  assign e_pitch = valid_r[proc_idx_r] ? ram_rdata[AGE_BITS +: PITCH_W] : '0;
  assign e_age   = valid_r[proc_idx_r] ? ram_rdata[AGE_BITS-1:0] : '0;

  assign scan_hit = pvalid_r &&
                    (((cmd_r.kind == CMD_NOTE_FREE) && !e_on) ||
                     ((cmd_r.kind == CMD_NOTE_OFF) && e_on && (e_pitch == cmd_r.pitch)));

  assign head_scans = (q_head.kind == CMD_NOTE_FREE) || (q_head.kind == CMD_NOTE_STEAL) ||
                      (q_head.kind == CMD_NOTE_OFF)  || (q_head.kind == CMD_STOP);

  assign set_idx = IW'(q_head.voice_select - 5'd1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty && head_scans) begin
          state_nxt = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_hit) begin
          state_nxt = BK_FLUSH;
        end else if (!pvalid_r) begin
          state_nxt = ((cmd_r.kind == CMD_NOTE_STEAL) && !off_fnd_r) ? BK_STEAL : BK_FLUSH;
        end
      end
      BK_STEAL: state_nxt = BK_FLUSH;
      BK_FLUSH: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = proc_idx_r;
    ram_wpitch   = cmd_r.pitch;
    ram_wage     = counter_r;
    ram_raddr    = rd_idx_r[IW-1:0];
    emit         = 1'b0;
    flush        = 1'b0;
    emit_item    = '{voice_number: vnum(proc_idx_r), out_pitch: cmd_r.pitch,
                     out_velocity: cmd_r.velocity, last: 1'b0};
    cmd_nxt      = cmd_r;
    rd_idx_nxt   = rd_idx_r;
    proc_idx_nxt = proc_idx_r;
    pvalid_nxt   = pvalid_r;
    on_nxt       = on_r;
    valid_nxt    = valid_r;
    counter_nxt  = counter_r;
    on_fnd_nxt   = on_fnd_r;
    on_idx_nxt   = on_idx_r;
    on_age_nxt   = on_age_r;
    on_pit_nxt   = on_pit_r;
    off_fnd_nxt  = off_fnd_r;
    off_idx_nxt  = off_idx_r;
    off_age_nxt  = off_age_r;

    unique case (state_r)
      BK_IDLE: begin
        ram_raddr = '0;
        if (!q_empty) begin
          q_pop        = 1'b1;
          cmd_nxt      = q_head;
          rd_idx_nxt   = CW'(1);
          proc_idx_nxt = '0;
          pvalid_nxt   = head_scans;
          on_fnd_nxt   = 1'b0;
          off_fnd_nxt  = 1'b0;
          unique case (q_head.kind)
            CMD_CLEAR: begin
              for (int i = 0; i < MAX_VOICES; i++) begin
                if (CW'(i) < nv) begin
                  on_nxt[i]    = 1'b0;
                  valid_nxt[i] = 1'b0;
                end
              end
            end
            CMD_SET: begin
              ram_we             = 1'b1;
              ram_waddr          = set_idx;
              ram_wpitch         = q_head.pitch;
              on_nxt[set_idx]    = (q_head.velocity != '0);
              valid_nxt[set_idx] = 1'b1;
              counter_nxt        = counter_r + AGE_BITS'(1);
            end
            default: ;
          endcase
        end
      end

      BK_SCAN: begin
        if (pvalid_r) begin
          rd_idx_nxt   = rd_idx_r + CW'(1);
          proc_idx_nxt = rd_idx_r[IW-1:0];
          pvalid_nxt   = (rd_idx_r < nv);
          unique case (cmd_r.kind)
            CMD_NOTE_FREE: begin
              if (!e_on) begin
                ram_we                = 1'b1;
                ram_wage              = '0;
                on_nxt[proc_idx_r]    = 1'b1;
                valid_nxt[proc_idx_r] = 1'b1;
                emit                  = 1'b1;
              end
            end
            CMD_NOTE_STEAL: begin
              if (e_on) begin
                if (!on_fnd_r || (e_age < on_age_r)) begin
                  on_fnd_nxt = 1'b1;
                  on_idx_nxt = proc_idx_r;
                  on_age_nxt = e_age;
                  on_pit_nxt = e_pitch;
                end
              end else if (!off_fnd_r || (e_age < off_age_r)) begin
                off_fnd_nxt = 1'b1;
                off_idx_nxt = proc_idx_r;
                off_age_nxt = e_age;
              end
            end
            CMD_NOTE_OFF: begin
              if (scan_hit) begin
                ram_we                 = 1'b1;
                counter_nxt            = counter_r + AGE_BITS'(1);
                on_nxt[proc_idx_r]     = 1'b0;
                valid_nxt[proc_idx_r]  = 1'b1;
                emit                   = 1'b1;
                emit_item.out_velocity = '0;
              end
            end
            CMD_STOP: begin
              if (e_on) begin
                ram_we                 = 1'b1;
                ram_wpitch             = e_pitch;
                counter_nxt            = counter_r + AGE_BITS'(1);
                on_nxt[proc_idx_r]     = 1'b0;
                valid_nxt[proc_idx_r]  = 1'b1;
                emit                   = 1'b1;
                emit_item.out_pitch    = e_pitch;
                emit_item.out_velocity = '0;
              end
            end
            default: ;
          endcase
        end else if (cmd_r.kind == CMD_NOTE_STEAL) begin
          if (off_fnd_r) begin
            ram_we                  = 1'b1;
            ram_waddr               = off_idx_r;
            counter_nxt             = counter_r + AGE_BITS'(1);
            on_nxt[off_idx_r]       = 1'b1;
            valid_nxt[off_idx_r]    = 1'b1;
            emit                    = 1'b1;
            emit_item.voice_number  = vnum(off_idx_r);
          end else begin
            // every voice busy: note-off of the oldest one goes first
            emit                    = 1'b1;
            emit_item.voice_number  = vnum(on_idx_r);
            emit_item.out_pitch     = on_pit_r;
            emit_item.out_velocity  = '0;
          end
        end
      end

      BK_STEAL: begin
        ram_we                 = 1'b1;
        ram_waddr              = on_idx_r;
        counter_nxt            = counter_r + AGE_BITS'(1);
        on_nxt[on_idx_r]       = 1'b1;
        valid_nxt[on_idx_r]    = 1'b1;
        emit                   = 1'b1;
        emit_item.voice_number = vnum(on_idx_r);
      end

      BK_FLUSH: flush = 1'b1;
    endcase
  end

  // result staging: a new result pushes the held one out as not-last
  always_comb begin
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    out_valid_nxt  = 1'b0;
    out_item_nxt   = pend_r;
    if (emit) begin
      pend_nxt          = emit_item;
      pend_valid_nxt    = 1'b1;
      out_valid_nxt     = pend_valid_r;
      out_item_nxt.last = 1'b0;
    end else if (flush) begin
      pend_valid_nxt    = 1'b0;
      out_valid_nxt     = pend_valid_r;
      out_item_nxt.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      pvalid_r     <= 1'b0;
      on_r         <= '0;
      valid_r      <= '0;
      counter_r    <= '0;
      on_fnd_r     <= 1'b0;
      off_fnd_r    <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pvalid_r     <= pvalid_nxt;
      on_r         <= on_nxt;
      valid_r      <= valid_nxt;
      counter_r    <= counter_nxt;
      on_fnd_r     <= on_fnd_nxt;
      off_fnd_r    <= off_fnd_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    rd_idx_r   <= rd_idx_nxt;
    proc_idx_r <= proc_idx_nxt;
    on_idx_r   <= on_idx_nxt;
    on_age_r   <= on_age_nxt;
    on_pit_r   <= on_pit_nxt;
    off_idx_r  <= off_idx_nxt;
    off_age_r  <= off_age_nxt;
    pend_r     <= pend_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `PVA_ASSERT_IMPLY(a_steal_sounding, state_r == BK_STEAL, on_r[on_idx_r], "steal target is not sounding")
  `PVA_ASSERT_IMPLY(a_last_from_flush, out_valid_r && out_item_r.last, $past(state_r == BK_FLUSH), "last result outside flush")
  `PVA_ASSERT_IMPLY(a_stamp_on_write, $past(rst_n) && (counter_r != $past(counter_r)), $past(ram_we), "counter moved without a voice write")

endmodule

[tb/pva_alloc_checker.sv]
`timescale 1ns / 100ps

// Watches the item, result and register channels of the allocator, keeps its own
// copy of the voice table and compares every result strobe against the oldest
// predicted voice event.
module pva_alloc_checker import pva_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          events_due
);

  localparam int NUM_VOICES = 16;
  localparam int SHOW_LIMIT = 10;

  // shadow registers and voice table
  logic        steal_on;
  logic [4:0]  voices_cfg;
  logic        voice_on   [NUM_VOICES];
  logic [31:0] voice_age  [NUM_VOICES];
  logic [6:0]  voice_pitch[NUM_VOICES];
  logic [31:0] event_ctr;

  out_item_t voice_events[$];
  int        shown;

  initial begin
    fail_count = 0;
    events_due = 0;
    shown      = 0;
  end

  task automatic clear_table();
    for (int i = 0; i < NUM_VOICES; i++) begin
      voice_on[i]    = 1'b0;
      voice_age[i]   = '0;
      voice_pitch[i] = '0;
    end
  endtask

  // 0 and anything past the table size mean the whole table
  function automatic int voices_in_use();
    if (voices_cfg == 0 || voices_cfg > NUM_VOICES)
      return NUM_VOICES;
    return int'(voices_cfg);
  endfunction

  function automatic logic [31:0] next_stamp();
    logic [31:0] s;
    s = event_ctr;
    event_ctr = event_ctr + 32'd1;
    return s;
  endfunction

  task automatic push_event(input int voice, input logic [6:0] p, input logic [6:0] vel);
    out_item_t ev;
    ev.voice_number = 5'(voice + 1);
    ev.out_pitch    = p;
    ev.out_velocity = vel;
    ev.last         = 1'b0;
    voice_events.push_back(ev);
  endtask

  task automatic allocate(input in_item_t it);
    int        nv;
    int        n;
    int        on_i;
    int        off_i;
    int        w;
    out_item_t tail;
    nv = voices_in_use();
    n  = 0;
    case (it.operation)
      OP_NOTE: begin
        if (it.velocity != 0) begin
          if (steal_on) begin
            on_i  = -1;
            off_i = -1;
            for (int i = 0; i < nv; i++) begin
              if (voice_on[i]) begin
                if (on_i < 0 || voice_age[i] < voice_age[on_i]) on_i = i;
              end else begin
                if (off_i < 0 || voice_age[i] < voice_age[off_i]) off_i = i;
              end
            end
            // table full: release the oldest sounding voice first
            if (off_i < 0) begin
              push_event(on_i, voice_pitch[on_i], 7'd0);
              n++;
              off_i = on_i;
            end
            voice_on[off_i]    = 1'b1;
            voice_pitch[off_i] = it.pitch;
            voice_age[off_i]   = next_stamp();
            push_event(off_i, it.pitch, it.velocity);
            n++;
          end else begin
            for (int i = 0; i < nv; i++) begin
              if (!voice_on[i]) begin
                voice_on[i]    = 1'b1;
                voice_pitch[i] = it.pitch;
                voice_age[i]   = '0;
                push_event(i, it.pitch, it.velocity);
                n++;
                break;
              end
            end
          end
        end else begin
          for (int i = 0; i < nv; i++) begin
            if (voice_on[i] && voice_pitch[i] == it.pitch) begin
              voice_on[i]  = 1'b0;
              voice_age[i] = next_stamp();
              push_event(i, it.pitch, 7'd0);
              n++;
              break;
            end
          end
        end
      end
      OP_STOP: begin
        for (int i = 0; i < nv; i++) begin
          if (voice_on[i]) begin
            push_event(i, voice_pitch[i], 7'd0);
            n++;
            voice_on[i]  = 1'b0;
            voice_age[i] = next_stamp();
          end
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < nv; i++) begin
          voice_on[i]    = 1'b0;
          voice_pitch[i] = '0;
          voice_age[i]   = '0;
        end
      end
      default: begin
        if (it.voice_select >= 1 && int'(it.voice_select) <= nv) begin
          w              = int'(it.voice_select) - 1;
          voice_pitch[w] = it.pitch;
          voice_on[w]    = (it.velocity != 0);
          voice_age[w]   = next_stamp();
        end
      end
    endcase
    if (n > 0) begin
      tail = voice_events.pop_back();
      tail.last = 1'b1;
      voice_events.push_back(tail);
    end
  endtask

  task automatic report(input string what, input out_item_t exp_ev, input out_item_t got);
    fail_count++;
    if (shown < SHOW_LIMIT) begin
      shown++;
      $display("%0t mismatch (%s): exp voice %0d pitch %0d vel %0d last %0b, got voice %0d pitch %0d vel %0d last %0b",
               $realtime, what, exp_ev.voice_number, exp_ev.out_pitch, exp_ev.out_velocity,
               exp_ev.last, got.voice_number, got.out_pitch, got.out_velocity, got.last);
    end
  endtask

  task automatic check_event(input out_item_t got);
    out_item_t exp_ev;
    if (voice_events.size() == 0) begin
      report("unexpected", '0, got);
    end else begin
      exp_ev = voice_events.pop_front();
      if (got.voice_number !== exp_ev.voice_number || got.out_pitch !== exp_ev.out_pitch ||
          got.out_velocity !== exp_ev.out_velocity || got.last !== exp_ev.last)
        report("field", exp_ev, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      steal_on   = 1'b0;
      voices_cfg = 5'd16;
      event_ctr  = '0;
      clear_table();
      voice_events.delete();
    end else begin
      // results first: none can stem from an item accepted at this same edge
      if (out_valid)
        check_event(out_item);
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_VOICE_COUNT) voices_cfg = pwdata[4:0];
        else                             steal_on   = pwdata[0];
      end
      if (start && !busy)
        allocate(in_item);
    end
    events_due <= voice_events.size();
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import pva_pkg::*;

  // With the 2-deep command queue three items can be in flight (one in the back
  // end, two queued), and DRAIN_CYCLES covers anything still queued that
  // produces no result.
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASES       = 7;
  localparam int PER_PHASE    = 27;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_valid;
  out_item_t   out_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int events_due;
  bit gaps_on;

  // register settings per random phase; 0 and 31 exercise the out-of-range count
  logic       phase_steal [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  logic [4:0] phase_count [PHASES] = '{5'd16, 5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd3};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  poly_voice_allocator_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // scoreboard sits beside the DUT and sees exactly what the DUT sees
  pva_alloc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .fail_count(fail_count),
    .events_due(events_due)
  );

  function automatic in_item_t note_cmd(input logic [1:0] op, input int p, input int vel,
                                        input int sel);
    in_item_t it;
    it.operation    = op;
    it.pitch        = 7'(p);
    it.velocity     = 7'(vel);
    it.voice_select = 5'(sel);
    return it;
  endfunction

  // Random idle cycles before an item; start drops for the gap.
  task automatic idle_gap();
    if (gaps_on) begin
      while ($urandom_range(99) < 38) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // Holds start with the item until an edge sees busy low. start stays high on
  // return so back-to-back items need no second assignment in one step.
  task automatic send_item(input in_item_t it);
    idle_gap();
    in_item <= it;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // Drop start, let every predicted event arrive, then cover items still in
  // the command queue that make no result.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (events_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup phase, access phase until pready, then an idle phase
  // so a following write starts on a fresh edge.
  task automatic cfg_write(input logic reg_sel, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Random item: mostly note-ons and note-offs over a small pitch pool so that
  // releases find their voices and the table fills up enough to steal.
  task automatic send_random();
    int r;
    int p;
    int vel;
    int sel;
    r   = $urandom_range(99);
    p   = ($urandom_range(99) < 70) ? $urandom_range(47, 40) : $urandom_range(127);
    sel = $urandom_range(31);
    if ($urandom_range(3) == 0) vel = ($urandom_range(1) != 0) ? 127 : 1;
    else                        vel = $urandom_range(127, 1);
    if (r < 50) begin
      send_item(note_cmd(OP_NOTE, p, vel, sel));
    end else if (r < 80) begin
      send_item(note_cmd(OP_NOTE, p, 0, sel));
    end else if (r < 90) begin
      // set: mostly a voice in range, sometimes zero or past the count
      if ($urandom_range(3) != 0) sel = $urandom_range(16, 1);
      send_item(note_cmd(OP_SET, p, $urandom_range(127), sel));
    end else if (r < 95) begin
      send_item(note_cmd(OP_STOP, p, vel, sel));
    end else begin
      send_item(note_cmd(OP_CLEAR, p, vel, sel));
    end
  endtask

  initial begin
    gaps_on = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed: reset defaults, lowest-free mode, 16 voices ---
    send_item(note_cmd(OP_NOTE, 0, 127, 31));   // voice 1
    send_item(note_cmd(OP_NOTE, 127, 1, 0));    // voice 2
    send_item(note_cmd(OP_NOTE, 0, 0, 0));      // release voice 1
    send_item(note_cmd(OP_NOTE, 55, 0, 0));     // release with no match: silent
    send_item(note_cmd(OP_SET, 20, 30, 0));     // voice zero: ignored
    send_item(note_cmd(OP_SET, 20, 30, 17));    // past the count: ignored
    send_item(note_cmd(OP_SET, 99, 1, 16));     // force top voice on
    send_item(note_cmd(OP_SET, 5, 0, 2));       // force voice 2 off
    send_item(note_cmd(OP_STOP, 0, 0, 0));      // releases the top voice
    send_item(note_cmd(OP_STOP, 0, 0, 0));      // nothing sounding
    send_item(note_cmd(OP_NOTE, 60, 64, 0));
    send_item(note_cmd(OP_CLEAR, 0, 0, 0));
    send_item(note_cmd(OP_NOTE, 60, 0, 0));     // cleared: no match
    drain();

    // --- directed: two voices with stealing ---
    cfg_write(REG_STEAL_MODE, 32'd1);
    cfg_write(REG_VOICE_COUNT, 32'd2);
    send_item(note_cmd(OP_NOTE, 10, 100, 0));   // equal ages: lowest voice wins
    send_item(note_cmd(OP_NOTE, 11, 90, 0));
    send_item(note_cmd(OP_NOTE, 12, 80, 0));    // full: steal oldest, two events
    send_item(note_cmd(OP_NOTE, 11, 0, 0));
    send_item(note_cmd(OP_NOTE, 13, 70, 0));
    send_item(note_cmd(OP_STOP, 0, 0, 0));
    drain();

    // --- directed: single voice, no stealing ---
    cfg_write(REG_STEAL_MODE, 32'd0);
    cfg_write(REG_VOICE_COUNT, 32'd1);
    send_item(note_cmd(OP_NOTE, 1, 1, 0));
    send_item(note_cmd(OP_NOTE, 2, 2, 0));      // no free voice: silent
    send_item(note_cmd(OP_NOTE, 1, 0, 0));
    drain();

    // --- random phases, each under its own register setting ---
    for (int ph = 0; ph < PHASES; ph++) begin
      cfg_write(REG_STEAL_MODE, {31'd0, phase_steal[ph]});
      cfg_write(REG_VOICE_COUNT, {27'd0, phase_count[ph]});
      gaps_on = (ph != 1);  // one phase runs with no gaps at all
      for (int k = 0; k < PER_PHASE; k++)
        send_random();
      drain();
    end

    if (fail_count == 0 && events_due == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
